### rtl/pal_pkg.sv
package pal_pkg;

  // field and bus widths
  localparam int WORD_W = 32;
  localparam int CMD_W  = 4;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 4;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 40;
  // index width inside the chain, covers positions up to the largest depth
  localparam int IDX_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_AT    = 4'd0,
    CMD_INSERT_FIRST = 4'd1,
    CMD_INSERT_LAST  = 4'd2,
    CMD_DELETE_AT    = 4'd3,
    CMD_DELETE_KEY   = 4'd4,
    CMD_REPLACE      = 4'd5,
    CMD_READ         = 4'd6,
    CMD_FIND         = 4'd7,
    CMD_CLEAR        = 4'd8
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_POS    = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  // action broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE_POS,
    OP_DELETE_KEY,
    OP_REPLACE,
    OP_READ
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          pos;
    logic signed [WORD_W-1:0]  word;
  } ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0]          count;
    logic signed [WORD_W-1:0]  key;
  } srch_t;

endpackage

### rtl/positional_array_list.sv
// positional_array_list: ordered list of signed 32-bit words, up to DEPTH entries
// input channel in_*: one command per transaction (insert, delete, replace,
//   read, find, clear); the list is held in a row of cells, one word each,
//   that shift up or down together in the cycle the command executes
// output channel out_*: exactly one result transaction per command, carrying
//   the word read or removed, the found flag, a status code and the new length
// result timing: the result is registered and shows on out_tvalid in the cycle
//   after the command is accepted
// throughput: one command per cycle unless stalled; a command executes in the cycle
//   it is accepted, bounded by the key compare and first-match chain across the cells
// stall: the output register holds its result while out_tready is low, and
//   in_tready stays low until that result is taken (or is taken this cycle)
// reset: rst_n (synchronous, active low) empties the list and drops out_tvalid;
//   the words in the cells are not cleared and are never read before written
module positional_array_list
  import pal_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command[3:0], position[7:4], data_word[39:8]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // read_word[31:0], found[32], status[34:33],
                                       // length[38:35], zero[39]
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // input fields
  cmd_t                     cmd;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] data_word;

  assign cmd       = cmd_t'(in_tdata[CMD_W-1:0]);
  assign position  = in_tdata[CMD_W+POS_W-1:CMD_W];
  assign data_word = in_tdata[CMD_W+POS_W+WORD_W-1:CMD_W+POS_W];

  // handshake
  logic in_fire;
  logic out_valid_r;
  logic out_valid_nxt;
  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  // list length
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] count_ext;
  logic [IDX_W-1:0] pos_ext;
  logic             full;

  assign count_ext = IDX_W'(count_r);
  assign pos_ext   = IDX_W'(position);
  assign full      = (count_r == CNT_W'(DEPTH));

  // cell chain wiring
  ctl_t                     ctl;
  srch_t                    srch;
  logic signed [WORD_W-1:0] entry_w [DEPTH];
  logic signed [WORD_W-1:0] pick_w  [DEPTH];
  logic                     found_w [DEPTH+1];
  logic signed [WORD_W-1:0] pick_bus;
  logic                     any_found;

  assign srch.count = count_ext;
  assign srch.key   = data_word;
  assign found_w[0] = 1'b0;
  assign any_found  = found_w[DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [WORD_W-1:0] left_w;
      logic signed [WORD_W-1:0] right_w;
      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = entry_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = entry_w[g+1];
      end
      pal_cell #(
        .INDEX(g)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .srch      (srch),
        .left_word (left_w),
        .right_word(right_w),
        .found_in  (found_w[g]),
        .entry     (entry_w[g]),
        .found_out (found_w[g+1]),
        .pick_word (pick_w[g])
      );
    end
  endgenerate

  // read bus, at most one cell drives a nonzero word
  always_comb begin
    pick_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_bus = pick_bus | pick_w[i];
    end
  end

  // command decode
  cell_op_t op_dec;
  logic [IDX_W-1:0] op_pos;
  status_t          status;
  logic             found;
  logic             use_pick;

  always_comb begin
    op_dec    = OP_NONE;
    op_pos    = pos_ext;
    status    = ST_OK;
    found     = 1'b0;
    use_pick  = 1'b0;
    count_nxt = count_r;
    case (cmd)
      CMD_INSERT_AT, CMD_INSERT_FIRST, CMD_INSERT_LAST: begin
        if (cmd == CMD_INSERT_FIRST) begin
          op_pos = '0;
        end else if (cmd == CMD_INSERT_LAST) begin
          op_pos = count_ext;
        end
        if (full) begin
          status = ST_FULL;
        end else if (cmd == CMD_INSERT_AT && pos_ext > count_ext) begin
          status = ST_POS;
        end else begin
          op_dec    = OP_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_DELETE_AT: begin
        if (pos_ext >= count_ext) begin
          status = ST_POS;
        end else begin
          op_dec    = OP_DELETE_POS;
          use_pick  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_DELETE_KEY: begin
        if (any_found) begin
          op_dec    = OP_DELETE_KEY;
          found     = 1'b1;
          use_pick  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status = ST_ABSENT;
        end
      end
      CMD_REPLACE: begin
        if (pos_ext >= count_ext) begin
          status = ST_POS;
        end else begin
          op_dec = OP_REPLACE;
        end
      end
      CMD_READ: begin
        if (pos_ext >= count_ext) begin
          status = ST_POS;
        end else begin
          op_dec   = OP_READ;
          use_pick = 1'b1;
        end
      end
      CMD_FIND: begin
        if (any_found) begin
          found = 1'b1;
        end else begin
          status = ST_ABSENT;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        op_dec = OP_NONE;
      end
    endcase
  end

  // cells only move on an accepted command
  assign ctl.op   = in_fire ? op_dec : OP_NONE;
  assign ctl.pos  = op_pos;
  assign ctl.word = data_word;

  // result packing
  logic [OUT_W-1:0]         out_data_r;
  logic [OUT_W-1:0]         out_data_nxt;
  logic signed [WORD_W-1:0] read_word;
  logic [IDX_W-1:0]         count_nxt_ext;

  assign read_word     = use_pick ? pick_bus : '0;
  assign count_nxt_ext = IDX_W'(count_nxt);
  assign out_data_nxt  = {1'b0, count_nxt_ext[LEN_W-1:0], status, found, read_word};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/pal_cell.sv
module pal_cell
  import pal_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  ctl_t                     ctl,
  input  srch_t                    srch,
  input  logic signed [WORD_W-1:0] left_word,
  input  logic signed [WORD_W-1:0] right_word,
  input  logic                     found_in,
  output logic signed [WORD_W-1:0] entry,
  output logic                     found_out,
  output logic signed [WORD_W-1:0] pick_word
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [WORD_W-1:0] entry_r;
  logic signed [WORD_W-1:0] entry_nxt;
  logic                     match;
  logic                     first;
  logic                     at_pos;
  logic                     pick;

  // key compare, only live entries count
  assign match     = (entry_r == srch.key) && (MY_IDX < srch.count);
  assign found_out = found_in | match;
  assign first     = match & ~found_in;
  assign at_pos    = (MY_IDX == ctl.pos);

  // contribution to the read bus
  assign pick = ((ctl.op == OP_READ || ctl.op == OP_DELETE_POS) && at_pos) ||
                ((ctl.op == OP_DELETE_KEY) && first);
  assign pick_word = pick ? entry_r : '0;

  // next entry from own word, new word or a neighbor
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      OP_INSERT: begin
        if (at_pos) begin
          entry_nxt = ctl.word;
        end else if (MY_IDX > ctl.pos) begin
          entry_nxt = left_word;
        end
      end
      OP_DELETE_POS: begin
        if (MY_IDX >= ctl.pos) begin
          entry_nxt = right_word;
        end
      end
      OP_DELETE_KEY: begin
        if (found_out) begin
          entry_nxt = right_word;
        end
      end
      OP_REPLACE: begin
        if (at_pos) begin
          entry_nxt = ctl.word;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

### tb/pal_result_checker.sv
module pal_result_checker
  import pal_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command[3:0], position[7:4], data_word[39:8]
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,  // read_word[31:0], found[32], status[34:33],
                                       // length[38:35], zero[39]
  output int               errors,
  output int               results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // one result transaction as it sits on out_tdata
  typedef struct packed {
    logic                     pad;
    logic [LEN_W-1:0]         length;
    status_t                  status;
    logic                     found;
    logic signed [WORD_W-1:0] read_word;
  } reply_t;

  // mirror of the list contents
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned              shadow_len;

  reply_t awaited_replies [$];
  int     mismatches = 0;
  int     owed = 0;

  assign errors       = mismatches;
  assign results_owed = owed;

  // keep the log bounded when the block is badly broken
  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    if (mismatches < 100)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // open a cell at pos, later entries move up
  function automatic void shift_in(int unsigned pos, logic signed [WORD_W-1:0] word);
    int unsigned i;
    for (i = shadow_len; i > pos; i--)
      shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = word;
    shadow_len++;
  endfunction

  // close the cell at pos, later entries move down
  function automatic logic signed [WORD_W-1:0] shift_out(int unsigned pos);
    logic signed [WORD_W-1:0] word;
    int unsigned              i;
    word = shadow_words[pos];
    for (i = pos; i + 1 < shadow_len; i++)
      shadow_words[i] = shadow_words[i+1];
    shadow_len--;
    return word;
  endfunction

  // executes one command on the mirror and returns the reply it should give
  function automatic reply_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                logic [POS_W-1:0] pos,
                                                logic signed [WORD_W-1:0] word);
    reply_t      r;
    bit          full;
    int          hit;
    int unsigned i;
    r      = '0;
    r.status = ST_OK;
    full   = shadow_len >= DEPTH;
    // first entry equal to the key
    hit    = -1;
    for (i = 0; i < shadow_len; i++)
      if (hit < 0 && shadow_words[i] == word) hit = i;
    case (cmd)
      CMD_INSERT_AT: begin
        if (full) r.status = ST_FULL;
        else if (pos > shadow_len) r.status = ST_POS;
        else shift_in(32'(pos), word);
      end
      CMD_INSERT_FIRST: begin
        if (full) r.status = ST_FULL;
        else shift_in(0, word);
      end
      CMD_INSERT_LAST: begin
        if (full) r.status = ST_FULL;
        else shift_in(shadow_len, word);
      end
      CMD_DELETE_AT: begin
        if (pos >= shadow_len) r.status = ST_POS;
        else r.read_word = shift_out(32'(pos));
      end
      CMD_DELETE_KEY: begin
        if (hit >= 0) begin
          r.found     = 1'b1;
          r.read_word = shift_out(hit);
        end else begin
          r.status = ST_ABSENT;
        end
      end
      CMD_REPLACE: begin
        if (pos >= shadow_len) r.status = ST_POS;
        else shadow_words[pos] = word;
      end
      CMD_READ: begin
        if (pos >= shadow_len) r.status = ST_POS;
        else r.read_word = shadow_words[pos];
      end
      CMD_FIND: begin
        if (hit >= 0) r.found = 1'b1;
        else r.status = ST_ABSENT;
      end
      CMD_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
        // unused codes leave the list alone
      end
    endcase
    r.length = shadow_len[LEN_W-1:0];
    return r;
  endfunction

  // compare each result, then predict for the command taken at this edge
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      awaited_replies.delete();
      shadow_len = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = reply_t'(out_tdata);
        if (awaited_replies.size() == 0) begin
          report_mismatch("result with no command pending", out_tdata[WORD_W-1:0], '0);
        end else begin
          want = awaited_replies.pop_front();
          if (got.read_word !== want.read_word)
            report_mismatch("read_word", got.read_word, want.read_word);
          if (got.found !== want.found)
            report_mismatch("found", WORD_W'(got.found), WORD_W'(want.found));
          if (got.status !== want.status)
            report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
          if (got.length !== want.length)
            report_mismatch("length", WORD_W'(got.length), WORD_W'(want.length));
          if (got.pad !== 1'b0)
            report_mismatch("padding bit", WORD_W'(got.pad), '0);
        end
      end
      if (in_tvalid && in_tready)
        awaited_replies.push_back(apply_list_command(in_tdata[3:0], in_tdata[7:4],
                                                     in_tdata[39:8]));
    end
    owed = awaited_replies.size();
  end

endmodule

### tb/tb_top.sv
module tb_top
  import pal_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH     = 8;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int DRAIN_CYCLES   = 4;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // command[3:0], position[7:4], data_word[39:8]
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // read_word[31:0], found[32], status[34:33],
                                // length[38:35], zero[39]
  int               errors;
  int               results_owed;
  int               idle_pct = 20;
  int               quiet_cycles = 0;

  always #6 clk = ~clk;

  positional_array_list #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  pal_result_checker #(
    .DEPTH(LIST_DEPTH)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .errors      (errors),
    .results_owed(results_owed)
  );

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // inserts outweigh deletes so the list often fills up
  function automatic logic [CMD_W-1:0] pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 14) return CMD_INSERT_AT;
    if (roll < 24) return CMD_INSERT_FIRST;
    if (roll < 36) return CMD_INSERT_LAST;
    if (roll < 48) return CMD_DELETE_AT;
    if (roll < 60) return CMD_DELETE_KEY;
    if (roll < 70) return CMD_REPLACE;
    if (roll < 82) return CMD_READ;
    if (roll < 94) return CMD_FIND;
    if (roll < 97) return CMD_CLEAR;
    return CMD_W'($urandom_range(9, 15));
  endfunction

  // half the words come from a tiny set so keys hit and duplicates occur
  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(0, 1) == 0) return WORD_W'($urandom_range(0, 7)) - 32'd4;
    return $urandom();
  endfunction

  // positions mostly from 0 to LIST_DEPTH, some up to 15, beyond the depth
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, LIST_DEPTH));
    return POS_W'($urandom_range(0, 15));
  endfunction

  // one command transaction, preceded by a random gap
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [WORD_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {word, pos, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // result side stalls
  initial begin
    int hold;
    out_tready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    int n;
    int idle_modes [3];
    idle_modes = '{0, 15, 50};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty list errors
    send_command(CMD_READ,         4'd0,  32'h0000_0000);
    send_command(CMD_DELETE_AT,    4'd0,  32'h0000_0000);
    send_command(CMD_FIND,         4'd0,  32'h0000_0000);
    send_command(CMD_DELETE_KEY,   4'd0,  32'hFFFF_FFFF);
    send_command(CMD_INSERT_AT,    4'd1,  32'h1234_5678);
    // fill up with extreme words, insert at the end position too
    send_command(CMD_INSERT_AT,    4'd0,  32'h8000_0000);
    send_command(CMD_INSERT_LAST,  4'd0,  32'h7FFF_FFFF);
    send_command(CMD_INSERT_FIRST, 4'd15, 32'hFFFF_FFFF);
    send_command(CMD_INSERT_AT,    4'd3,  32'h0000_0000);
    send_command(CMD_INSERT_AT,    4'd15, 32'h0000_0001);
    send_command(CMD_INSERT_AT,    4'd2,  32'h5555_5555);
    send_command(CMD_INSERT_LAST,  4'd0,  32'hAAAA_AAAA);
    send_command(CMD_INSERT_FIRST, 4'd0,  32'h0000_0001);
    send_command(CMD_INSERT_LAST,  4'd0,  32'h7FFF_FFFF);
    // full list, full wins over a bad position
    send_command(CMD_INSERT_FIRST, 4'd0,  32'h0000_0002);
    send_command(CMD_INSERT_AT,    4'd15, 32'h0000_0003);
    send_command(CMD_INSERT_LAST,  4'd0,  32'h0000_0004);
    // duplicate key, first match goes
    send_command(CMD_FIND,         4'd0,  32'h7FFF_FFFF);
    send_command(CMD_DELETE_KEY,   4'd0,  32'h7FFF_FFFF);
    send_command(CMD_REPLACE,      4'd7,  32'h0BAD_F00D);
    send_command(CMD_REPLACE,      4'd6,  32'hFFFF_FFFF);
    send_command(CMD_READ,         4'd15, 32'h0000_0000);
    send_command(CMD_READ,         4'd6,  32'h0000_0000);
    send_command(CMD_DELETE_AT,    4'd0,  32'h0000_0000);
    send_command(4'd9,             4'd0,  32'h0000_0000);
    send_command(4'd15,            4'd15, 32'hFFFF_FFFF);
    send_command(CMD_CLEAR,        4'd0,  32'h0000_0000);
    send_command(CMD_READ,         4'd0,  32'h0000_0000);

    // random traffic, idle rate changes by phase
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 125 == 0) idle_pct = idle_modes[$urandom_range(0, 2)];
      send_command(pick_command(), pick_position(), pick_word());
    end
    in_tvalid <= 1'b0;

    // drain, then allow for the output register
    @(posedge clk);
    wait (results_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/positional_array_list.sv
tb/pal_result_checker.sv
tb/tb_top.sv
